// ===== sv/mslgf_pkg.sv =====
// Shared types and constants for the missing-sample linear gap filler.
package mslgf_pkg;

    localparam int GAP_W = 6;

    typedef logic [GAP_W-1:0] gap_t;

    typedef enum logic [1:0] {
        EMIT_MISS,
        EMIT_OVF,
        EMIT_FILL,
        EMIT_SAMPLE
    } emit_kind_t;

    typedef enum logic [1:0] {
        ST_KEEP,
        ST_PEND_INC,
        ST_OVF,
        ST_ANCHOR
    } st_op_t;

    typedef struct packed {
        logic       load;
        st_op_t     st_op;
        logic       st_clear;
        logic       div_step;
        logic       mul;
        logic       acc_init;
        logic       emit;
        emit_kind_t kind;
        logic       last;
        logic       series_end;
    } ctrl_cmd_t;

    typedef struct packed {
        logic anchor_valid;
        logic in_ovf;
        logic pend_full;
        gap_t pending;
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== sv/mslgf_dpath.sv =====
// Datapath: anchor state, serial divider, step multiplier, fill accumulator, output register.
module mslgf_dpath
    import mslgf_pkg::*;
#(
    parameter int MAX_GAP      = 63,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ctrl_cmd_t                      cmd,
    output dp_stat_t                       stat,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] out_value,
    output logic                           out_missing,
    output logic                           out_filled,
    output logic                           gap_overflow,
    output logic                           out_series_end,
    output logic                           run_last
);

    localparam int W     = SAMPLE_WIDTH;
    localparam int CNT_W = $clog2(SAMPLE_WIDTH);
    localparam int DVS_W = GAP_W + 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_WIDTH - 1);
    localparam gap_t GAP_MAX = gap_t'(MAX_GAP);

    logic             anchor_valid_reg, anchor_valid_next;
    logic [W-1:0]     anchor_value_reg;
    gap_t             pending_reg, pending_next;
    logic             in_ovf_reg, in_ovf_next;
    logic             out_valid_reg, out_valid_next;

    logic [W-1:0]     smp_reg;
    logic             rising_reg;
    logic [DVS_W-1:0] dvs_reg;
    gap_t             k_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [W-1:0]     quo_reg;
    logic [CNT_W-1:0] div_cnt_reg;
    logic [W-1:0]     off_reg;
    logic [W-1:0]     acc_reg;

    logic [W-1:0]     out_value_reg;
    logic             out_missing_reg;
    logic             out_filled_reg;
    logic             gap_overflow_reg;
    logic             out_series_end_reg;
    logic             run_last_reg;

    logic             rising_in;
    logic [W-1:0]     mag_in;
    logic [DVS_W-1:0] div_sh;
    logic [DVS_W:0]   div_trial;
    logic [W+GAP_W-1:0] prod;
    logic [W-1:0]     emit_value;

    always_comb
    begin
        rising_in = $signed(sample_value) >= $signed(anchor_value_reg);
        mag_in    = rising_in ? (W'(sample_value) - anchor_value_reg)
                              : (anchor_value_reg - W'(sample_value));
        div_sh    = {rem_reg[GAP_W-1:0], quo_reg[W-1]};
        div_trial = {1'b0, div_sh} - {1'b0, dvs_reg};
        prod      = {{GAP_W{1'b0}}, quo_reg} * {{W{1'b0}}, k_reg};
    end

    always_comb
    begin
        emit_value = '0;
        case (cmd.kind)
            EMIT_FILL:   emit_value = acc_reg;
            EMIT_SAMPLE: emit_value = smp_reg;
            default:     emit_value = '0;
        endcase
    end

    // anchor state is updated when the transaction is taken
    always_comb
    begin
        anchor_valid_next = anchor_valid_reg;
        pending_next      = pending_reg;
        in_ovf_next       = in_ovf_reg;
        if (cmd.load)
        begin
            unique case (cmd.st_op)
                ST_KEEP:
                begin
                end
                ST_PEND_INC:
                begin
                    pending_next = pending_reg + gap_t'(1);
                end
                ST_OVF:
                begin
                    pending_next = '0;
                    in_ovf_next  = 1'b1;
                end
                ST_ANCHOR:
                begin
                    anchor_valid_next = 1'b1;
                    pending_next      = '0;
                    in_ovf_next       = 1'b0;
                end
                default:
                begin
                end
            endcase
            if (cmd.st_clear)
            begin
                anchor_valid_next = 1'b0;
                pending_next      = '0;
                in_ovf_next       = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_valid_reg <= 1'b0;
            pending_reg      <= '0;
            in_ovf_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            anchor_valid_reg <= anchor_valid_next;
            pending_reg      <= pending_next;
            in_ovf_reg       <= in_ovf_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            smp_reg     <= sample_value;
            rising_reg  <= rising_in;
            quo_reg     <= mag_in;
            rem_reg     <= '0;
            dvs_reg     <= {1'b0, pending_reg} + DVS_W'(1);
            k_reg       <= pending_reg;
            div_cnt_reg <= CNT_LAST;
            if (cmd.st_op == ST_ANCHOR)
            begin
                anchor_value_reg <= sample_value;
            end
        end
        else if (cmd.div_step)
        begin
            quo_reg     <= {quo_reg[W-2:0], ~div_trial[DVS_W]};
            rem_reg     <= div_trial[DVS_W] ? div_sh : div_trial[DVS_W-1:0];
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
        end

        if (cmd.mul)
        begin
            off_reg <= prod[W-1:0];
        end

        if (cmd.acc_init)
        begin
            acc_reg <= rising_reg ? (smp_reg - off_reg) : (smp_reg + off_reg);
        end
        else if (cmd.emit && cmd.kind == EMIT_FILL)
        begin
            acc_reg <= rising_reg ? (acc_reg + quo_reg) : (acc_reg - quo_reg);
        end

        if (cmd.emit)
        begin
            out_value_reg      <= emit_value;
            out_missing_reg    <= (cmd.kind == EMIT_MISS) || (cmd.kind == EMIT_OVF);
            out_filled_reg     <= cmd.kind == EMIT_FILL;
            gap_overflow_reg   <= cmd.kind == EMIT_OVF;
            out_series_end_reg <= cmd.series_end;
            run_last_reg       <= cmd.last;
        end
    end

    always_comb
    begin
        stat.anchor_valid = anchor_valid_reg;
        stat.in_ovf       = in_ovf_reg;
        stat.pend_full    = pending_reg >= GAP_MAX;
        stat.pending      = pending_reg;
        stat.div_last     = div_cnt_reg == '0;
        stat.out_free     = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign out_value      = out_value_reg;
    assign out_missing    = out_missing_reg;
    assign out_filled     = out_filled_reg;
    assign gap_overflow   = gap_overflow_reg;
    assign out_series_end = out_series_end_reg;
    assign run_last       = run_last_reg;

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= GAP_MAX)
        else $error("held run longer than MAX_GAP");

    a_ovf_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_ovf_reg |-> (anchor_valid_reg && pending_reg == '0))
        else $error("overflow set with held run or without anchor");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result written over an untaken result");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !(cmd.emit || cmd.div_step || cmd.mul || cmd.acc_init))
        else $error("transaction taken while datapath busy");

endmodule

// ===== sv/mslgf_ctrl.sv =====
// Controller: decodes each input transaction and sequences division, fill and emission.
module mslgf_ctrl
    import mslgf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      sample_missing,
    input  logic      series_end,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_ACC,
        S_FILL,
        S_RUN,
        S_SMP
    } state_t;

    state_t     state_reg, state_next;
    gap_t       cnt_reg, cnt_next;
    emit_kind_t kind_reg, kind_next;
    logic       end_reg, end_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        end_next   = end_reg;
        cmd        = '0;
        cmd.st_op  = ST_KEEP;
        cmd.kind   = EMIT_MISS;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    cmd.st_clear = series_end;
                    end_next     = series_end;
                    if (sample_missing)
                    begin
                        if (!stat.anchor_valid)
                        begin
                            kind_next  = EMIT_MISS;
                            cnt_next   = '0;
                            state_next = S_RUN;
                        end
                        else if (stat.in_ovf)
                        begin
                            kind_next  = EMIT_OVF;
                            cnt_next   = '0;
                            state_next = S_RUN;
                        end
                        else if (stat.pend_full)
                        begin
                            cmd.st_op  = ST_OVF;
                            kind_next  = EMIT_OVF;
                            cnt_next   = stat.pending;
                            state_next = S_RUN;
                        end
                        else if (series_end)
                        begin
                            kind_next  = EMIT_MISS;
                            cnt_next   = stat.pending;
                            state_next = S_RUN;
                        end
                        else
                        begin
                            cmd.st_op = ST_PEND_INC;
                        end
                    end
                    else
                    begin
                        cmd.st_op = ST_ANCHOR;
                        if (stat.anchor_valid && !stat.in_ovf && stat.pending != '0)
                        begin
                            cnt_next   = stat.pending - gap_t'(1);
                            state_next = S_DIV;
                        end
                        else
                        begin
                            state_next = S_SMP;
                        end
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_init = 1'b1;
                state_next   = S_FILL;
            end
            S_FILL:
            begin
                cmd.kind = EMIT_FILL;
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = S_SMP;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - gap_t'(1);
                    end
                end
            end
            S_RUN:
            begin
                cmd.kind       = kind_reg;
                cmd.last       = cnt_reg == '0;
                cmd.series_end = end_reg && (cnt_reg == '0);
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - gap_t'(1);
                    end
                end
            end
            S_SMP:
            begin
                cmd.kind       = EMIT_SAMPLE;
                cmd.last       = 1'b1;
                cmd.series_end = end_reg;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            kind_reg  <= EMIT_MISS;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            kind_reg  <= kind_next;
            end_reg   <= end_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    a_fill_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (kind_reg == EMIT_MISS || kind_reg == EMIT_OVF))
        else $error("unfilled run with wrong result kind");

    a_div_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && stat.div_last) |=> (state_reg == S_MUL))
        else $error("division end not followed by multiply");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (state_reg == S_IDLE))
        else $error("last result of a transaction not followed by idle");

endmodule

// ===== sv/missing_sample_linear_gap_fill.sv =====
// Top level: fills inner runs of missing Q16.16 samples by linear interpolation.
// A held missing sample only adds to the held-run count; an unfilled run emits one
// result per missing sample. A present sample closing a gap passes S_DIV, S_MUL and
// S_ACC: the serial divider retires one quotient bit per cycle, then one result per
// cycle while the output is free; in_ready is low until the last result is emitted.
// rst_n clears anchor, held-run count, overflow flag, controller and output valid.
module missing_sample_linear_gap_fill
    import mslgf_pkg::*;
#(
    parameter int MAX_GAP      = 63,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
    input  logic                           sample_missing,
    input  logic                           series_end,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] out_value,
    output logic                           out_missing,
    output logic                           out_filled,
    output logic                           gap_overflow,
    output logic                           out_series_end,
    output logic                           run_last
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    mslgf_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_missing (sample_missing),
        .series_end     (series_end),
        .stat           (stat),
        .cmd            (cmd)
    );

    mslgf_dpath #(
        .MAX_GAP      (MAX_GAP),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .sample_value   (sample_value),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .out_value      (out_value),
        .out_missing    (out_missing),
        .out_filled     (out_filled),
        .gap_overflow   (gap_overflow),
        .out_series_end (out_series_end),
        .run_last       (run_last)
    );

endmodule

// ===== sim/tb_missing_sample_linear_gap_fill.sv =====
`timescale 1ns / 100ps
// Testbench for the missing-sample linear gap filler: directed and random series, checked per field.
module tb_missing_sample_linear_gap_fill
    import mslgf_pkg::*;
();

    localparam int GAP_LIMIT    = 63;
    localparam int RANDOM_ITEMS = 60;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 10000000;

    typedef struct packed {
        logic [31:0] value;
        logic        missing;
        logic        filled;
        logic        overflow;
        logic        last_of_series;
        logic        last_of_item;
    } sample_rec_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] sample_value;
    logic               sample_missing;
    logic               series_end;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] out_value;
    logic               out_missing;
    logic               out_filled;
    logic               gap_overflow;
    logic               out_series_end;
    logic               run_last;

    sample_rec_t expected_samples[$];
    logic        anchor_ok;
    logic [31:0] anchor_q;
    gap_t        held_count;
    logic        run_overflowed;
    logic [31:0] prev_value;
    logic        idle_on;
    int          sent_count;
    int          errors;
    int          cycles = 0;

    missing_sample_linear_gap_fill #(
        .MAX_GAP      (GAP_LIMIT),
        .SAMPLE_WIDTH (32)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_value   (sample_value),
        .sample_missing (sample_missing),
        .series_end     (series_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_value      (out_value),
        .out_missing    (out_missing),
        .out_filled     (out_filled),
        .gap_overflow   (gap_overflow),
        .out_series_end (out_series_end),
        .run_last       (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("tb_missing_sample_linear_gap_fill: FAIL");
            $finish;
        end
    end

    function automatic int idle_len(input logic enable);
        int r;
        if (!enable)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    function automatic logic [31:0] rand_sample(input logic [31:0] near);
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return near + 32'($urandom_range(8191)) - 32'd4096;
            3: return $urandom_range(1) ? 32'h0000_0000 : 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic sample_rec_t make_rec(input logic [31:0] value, input logic miss,
                                             input logic fill, input logic ovf);
        sample_rec_t r;
        r.value          = value;
        r.missing        = miss;
        r.filled         = fill;
        r.overflow       = ovf;
        r.last_of_series = 1'b0;
        r.last_of_item   = 1'b0;
        return r;
    endfunction

    task automatic predict_gap_fill(input logic [31:0] v, input logic miss, input logic fin);
        sample_rec_t res[$];
        logic [32:0] diff;
        logic [32:0] mag;
        logic [32:0] step;
        logic [63:0] off;
        logic        rising;
        int          k;
        int          i;
        k = int'(held_count);
        if (miss)
        begin
            if (!anchor_ok)
                res.push_back(make_rec(32'h0, 1'b1, 1'b0, 1'b0));
            else if (run_overflowed)
                res.push_back(make_rec(32'h0, 1'b1, 1'b0, 1'b1));
            else if (k >= GAP_LIMIT)
            begin
                for (i = 0; i <= k && i < 64; i++)
                    res.push_back(make_rec(32'h0, 1'b1, 1'b0, 1'b1));
                held_count     = '0;
                run_overflowed = 1'b1;
            end
            else if (fin)
            begin
                for (i = 0; i <= k; i++)
                    res.push_back(make_rec(32'h0, 1'b1, 1'b0, 1'b0));
                held_count = '0;
            end
            else
                held_count = gap_t'(k + 1);
        end
        else
        begin
            if (anchor_ok && !run_overflowed && k > 0)
            begin
                rising = $signed(v) >= $signed(anchor_q);
                diff   = {v[31], v} - {anchor_q[31], anchor_q};
                mag    = rising ? diff : -diff;
                step   = mag / 33'(k + 1);
                for (i = k; i >= 1; i--)
                begin
                    off = 64'(step) * 64'(i);
                    res.push_back(make_rec(rising ? v - off[31:0] : v + off[31:0],
                                           1'b0, 1'b1, 1'b0));
                end
            end
            res.push_back(make_rec(v, 1'b0, 1'b0, 1'b0));
            anchor_ok      = 1'b1;
            anchor_q       = v;
            held_count     = '0;
            run_overflowed = 1'b0;
        end
        if (res.size() > 0)
        begin
            res[res.size()-1].last_of_item   = 1'b1;
            res[res.size()-1].last_of_series = fin;
        end
        if (fin)
        begin
            anchor_ok      = 1'b0;
            anchor_q       = '0;
            held_count     = '0;
            run_overflowed = 1'b0;
        end
        foreach (res[j])
            expected_samples.push_back(res[j]);
    endtask

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_sample(input logic [31:0] v, input logic miss, input logic fin);
        int n;
        n = idle_len(idle_on);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid       <= 1'b1;
        sample_value   <= v;
        sample_missing <= miss;
        series_end     <= fin;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        predict_gap_fill(v, miss, fin);
        sent_count++;
        if (!miss)
            prev_value = v;
    endtask

    task automatic send_missing_run(input int n, input logic end_on_last);
        int i;
        for (i = 0; i < n; i++)
            send_sample($urandom, 1'b1, end_on_last && (i == n - 1));
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(negedge clk)
    begin
        sample_rec_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected transaction expected none actual value %0h",
                         $time, out_value);
                errors++;
            end
            else
            begin
                want = expected_samples.pop_front();
                check_field("out_value", want.value, out_value);
                check_field("out_missing", 32'(want.missing), 32'(out_missing));
                check_field("out_filled", 32'(want.filled), 32'(out_filled));
                check_field("gap_overflow", 32'(want.overflow), 32'(gap_overflow));
                check_field("out_series_end", 32'(want.last_of_series), 32'(out_series_end));
                check_field("run_last", 32'(want.last_of_item), 32'(run_last));
            end
        end
    end

    initial
    begin
        int n;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_ready <= 1'b1;
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(100, 20)) @(posedge clk);
            else
            begin
                repeat ($urandom_range(8, 1)) @(posedge clk);
                n = idle_len(1'b1);
                if (n > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    task automatic test_leading_missing();
        send_missing_run(2, 1'b0);
        send_missing_run(1, 1'b1);
    endtask

    task automatic test_interpolation();
        send_sample(32'h0000_0000, 1'b0, 1'b0);
        send_missing_run(3, 1'b0);
        send_sample(32'h0004_0000, 1'b0, 1'b0);
        send_missing_run(2, 1'b0);
        send_sample(32'hfffd_0000, 1'b0, 1'b0);
        send_missing_run(1, 1'b0);
        send_sample(32'hfffd_0000, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b0, 1'b0);
        send_missing_run(1, 1'b0);
        send_sample(32'h7fff_ffff, 1'b0, 1'b0);
        send_missing_run(4, 1'b0);
        send_sample(32'h8000_0000, 1'b0, 1'b0);
        send_missing_run(2, 1'b0);
        send_sample(32'h0000_0007, 1'b0, 1'b1);
    endtask

    task automatic test_trailing_run();
        send_sample(32'h0005_0000, 1'b0, 1'b0);
        send_missing_run(3, 1'b1);
        send_sample(32'h0001_8000, 1'b0, 1'b0);
        send_missing_run(1, 1'b1);
        send_sample(32'hffff_0000, 1'b0, 1'b1);
    endtask

    task automatic test_gap_overflow();
        send_sample(32'h0001_0000, 1'b0, 1'b0);
        send_missing_run(GAP_LIMIT, 1'b0);
        send_sample(32'hffff_0000, 1'b0, 1'b0);
        send_missing_run(GAP_LIMIT + 2, 1'b0);
        send_sample(32'h0002_0000, 1'b0, 1'b0);
        send_missing_run(2, 1'b0);
        send_sample(32'h0003_0000, 1'b0, 1'b0);
        send_missing_run(GAP_LIMIT + 1, 1'b1);
        send_sample(32'h0000_0000, 1'b0, 1'b0);
        send_missing_run(GAP_LIMIT + 2, 1'b1);
    endtask

    task automatic run_random_series();
        int nseg;
        int g;
        int r;
        int s;
        logic trailing;
        idle_on  = ($urandom_range(3) != 0);
        nseg     = $urandom_range(6, 1);
        trailing = ($urandom_range(3) == 0);
        if ($urandom_range(9) == 0)
        begin
            send_missing_run($urandom_range(4, 1), 1'b1);
            return;
        end
        if ($urandom_range(4) == 0)
            send_missing_run($urandom_range(3, 1), 1'b0);
        for (s = 0; s < nseg; s++)
        begin
            r = $urandom_range(99);
            if (s == 0 || r < 25)
                g = 0;
            else if (r < 75)
                g = $urandom_range(4, 1);
            else if (r < 90)
                g = $urandom_range(20, 5);
            else if (r < 96)
                g = $urandom_range(GAP_LIMIT, GAP_LIMIT - 5);
            else
                g = $urandom_range(GAP_LIMIT + 7, GAP_LIMIT + 1);
            send_missing_run(g, 1'b0);
            send_sample(rand_sample(prev_value), 1'b0, !trailing && (s == nseg - 1));
        end
        if (trailing)
        begin
            if ($urandom_range(5) == 0)
                send_missing_run($urandom_range(GAP_LIMIT + 2, GAP_LIMIT - 1), 1'b1);
            else
                send_missing_run($urandom_range(5, 1), 1'b1);
        end
    endtask

    task automatic test_random_series();
        int start;
        start = sent_count;
        while (sent_count - start < RANDOM_ITEMS)
            run_random_series();
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        sample_value   <= '0;
        sample_missing <= 1'b0;
        series_end     <= 1'b0;
        anchor_ok      = 1'b0;
        anchor_q       = '0;
        held_count     = '0;
        run_overflowed = 1'b0;
        prev_value     = '0;
        idle_on        = 1'b1;
        sent_count     = 0;
        errors         = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_leading_missing();
        test_interpolation();
        test_trailing_run();
        test_gap_overflow();
        test_random_series();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_missing_sample_linear_gap_fill: PASS");
        else
            $display("tb_missing_sample_linear_gap_fill: FAIL");
        $finish;
    end

endmodule
